// ===== src/dws_pkg.sv =====
// Shared types and constants for the dual-wheel speed PID block.
// Used by every module under src; depends on nothing.
package dws_pkg;

  localparam int CountW = 32;
  localparam int TargetW = 16;
  localparam int GainW = 16;
  localparam int LimitW = 15;
  localparam int DriveW = 16;
  localparam int IntegW = 48;
  localparam int ErrW = CountW + 1;
  localparam int ProdW = GainW + 1 + ErrW;
  localparam int SumW = ProdW + 2;
  localparam int CfgIdxW = 3;

  localparam logic [GainW-1:0] PropReset = 16'd20;
  localparam logic [GainW-1:0] DerivReset = 16'd20;
  localparam logic [GainW-1:0] IntegReset = 16'd0;
  localparam logic [GainW-1:0] DivisorReset = 16'd50;
  localparam logic [LimitW-1:0] LimitReset = 15'd255;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP    = 3'd0,
    REG_DERIV   = 3'd1,
    REG_INTEG   = 3'd2,
    REG_DIVISOR = 3'd3,
    REG_LIMIT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [GainW-1:0]  prop_gain;
    logic [GainW-1:0]  deriv_gain;
    logic [GainW-1:0]  integ_gain;
    logic [GainW-1:0]  divisor;
    logic [LimitW-1:0] max_drive;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic               moving;
    logic               load;
    logic [TargetW-1:0] target;
    logic [CountW-1:0]  count;
  } lane_cmd_t;

  typedef struct packed {
    logic              done;
    logic [DriveW-1:0] drive;
  } lane_res_t;

endpackage

// ===== src/dws_div.sv =====
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on dws_pkg; instantiated by dws_lane.
module dws_div
  import dws_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SumW-1:0]   dividend,
  input  logic [GainW-1:0]  divisor,
  output logic              done,
  output logic [SumW-1:0]   quotient
);

  localparam int CntW = $clog2(SumW);
  localparam logic [CntW-1:0] LastStep = CntW'(SumW - 1);

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_DONE = 3'b100
  } dv_state_t;

  dv_state_t       state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [SumW-1:0] quo_r, quo_nxt;
  logic [GainW-1:0] rem_r, rem_nxt;
  logic [GainW-1:0] dvs_r, dvs_nxt;
  logic            neg_r, neg_nxt;
  logic [GainW:0]  trial;
  logic [GainW:0]  diff;
  logic            ge;

  assign trial = {rem_r, quo_r[SumW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_nxt   = neg_r;
    case (state_r)
      DV_IDLE: begin
        if (start) begin
          neg_nxt   = dividend[SumW-1];
          quo_nxt   = dividend[SumW-1] ? (~dividend + 1'b1) : dividend;
          rem_nxt   = '0;
          dvs_nxt   = divisor;
          cnt_nxt   = '0;
          state_nxt = DV_RUN;
        end
      end
      DV_RUN: begin
        quo_nxt = {quo_r[SumW-2:0], ge};
        rem_nxt = ge ? diff[GainW-1:0] : trial[GainW-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LastStep) begin
          state_nxt = DV_DONE;
        end
      end
      DV_DONE: begin
        state_nxt = DV_IDLE;
      end
      default: begin
        state_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = (state_r == DV_DONE);
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ===== src/dws_lane.sv =====
// One wheel's PID lane: state, shared gain multiplier, divider, clamp and integral.
// Depends on dws_pkg and dws_div; two copies run in lockstep under the top level.
module dws_lane
  import dws_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  lane_cmd_t cmd,
  input  logic      ack,
  output lane_res_t res
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MP   = 7'b0000010,
    ST_MD   = 7'b0000100,
    ST_MI   = 7'b0001000,
    ST_SUM  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } ln_state_t;

  localparam logic signed [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
  localparam logic signed [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};

  ln_state_t                 state_r, state_nxt;
  logic [TargetW-1:0]        target_r, target_nxt;
  logic [CountW-1:0]         pcount_r, pcount_nxt;
  logic [CountW-1:0]         prate_r, prate_nxt;
  logic signed [IntegW-1:0]  integ_r, integ_nxt;
  logic signed [ErrW-1:0]    err_r, err_nxt;
  logic signed [ErrW-1:0]    drate_r, drate_nxt;
  logic signed [ProdW-1:0]   pterm_r, pterm_nxt;
  logic signed [ProdW-1:0]   dterm_r, dterm_nxt;
  logic signed [ProdW-1:0]   iterm_r, iterm_nxt;
  logic [DriveW-1:0]         drive_r, drive_nxt;

  logic [TargetW-1:0]        tgt_eff;
  logic [CountW-1:0]         rate;
  logic [GainW-1:0]          mul_gain;
  logic signed [ErrW-1:0]    mul_val;
  logic signed [ProdW-1:0]   product;
  logic signed [SumW-1:0]    sum;
  logic                      div_start;
  logic                      div_done;
  logic [SumW-1:0]           div_q;
  logic signed [SumW-1:0]    q;
  logic signed [SumW-1:0]    lim;
  logic signed [SumW-1:0]    acc;

  assign tgt_eff = cmd.load ? cmd.target : target_r;
  assign rate    = cmd.count - pcount_r;

  always_comb begin
    case (state_r)
      ST_MD:   begin mul_gain = cfg.deriv_gain; mul_val = drate_r; end
      ST_MI:   begin mul_gain = cfg.integ_gain; mul_val = err_r;   end
      default: begin mul_gain = cfg.prop_gain;  mul_val = err_r;   end
    endcase
  end

  assign product = $signed({1'b0, mul_gain}) * mul_val;

  assign sum = SumW'(pterm_r) - SumW'(dterm_r) + SumW'(integ_r);
  assign div_start = (state_r == ST_SUM);

  dws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum),
    .divisor  (cfg.divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q   = $signed(div_q);
  assign lim = $signed({{(SumW-LimitW){1'b0}}, cfg.max_drive});
  assign acc = SumW'(integ_r) + SumW'(iterm_r);

  always_comb begin
    state_nxt  = state_r;
    target_nxt = target_r;
    pcount_nxt = pcount_r;
    prate_nxt  = prate_r;
    integ_nxt  = integ_r;
    err_nxt    = err_r;
    drate_nxt  = drate_r;
    pterm_nxt  = pterm_r;
    dterm_nxt  = dterm_r;
    iterm_nxt  = iterm_r;
    drive_nxt  = drive_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          target_nxt = tgt_eff;
          if (!cmd.moving) begin
            if (prate_r != '0) begin
              target_nxt = '0;
              pcount_nxt = cmd.count;
              prate_nxt  = '0;
              integ_nxt  = '0;
            end
          end else begin
            err_nxt    = ErrW'($signed(tgt_eff)) - ErrW'($signed(rate));
            drate_nxt  = ErrW'($signed(rate)) - ErrW'($signed(prate_r));
            pcount_nxt = cmd.count;
            prate_nxt  = rate;
            state_nxt  = ST_MP;
          end
        end
      end
      ST_MP: begin
        pterm_nxt = product;
        state_nxt = ST_MD;
      end
      ST_MD: begin
        dterm_nxt = product;
        state_nxt = ST_MI;
      end
      ST_MI: begin
        iterm_nxt = product;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (q >= lim) begin
            drive_nxt = lim[DriveW-1:0];
          end else if (q <= -lim) begin
            drive_nxt = DriveW'(-lim);
          end else begin
            drive_nxt = q[DriveW-1:0];
            if (acc[SumW-1:IntegW-1] != {(SumW-IntegW+1){acc[SumW-1]}}) begin
              integ_nxt = acc[SumW-1] ? IntegMin : IntegMax;
            end else begin
              integ_nxt = acc[IntegW-1:0];
            end
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      target_r <= '0;
      pcount_r <= '0;
      prate_r  <= '0;
      integ_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      target_r <= target_nxt;
      pcount_r <= pcount_nxt;
      prate_r  <= prate_nxt;
      integ_r  <= integ_nxt;
    end
    err_r   <= err_nxt;
    drate_r <= drate_nxt;
    pterm_r <= pterm_nxt;
    dterm_r <= dterm_nxt;
    iterm_r <= iterm_nxt;
    drive_r <= drive_nxt;
  end

  assign res.done  = (state_r == ST_FIN);
  assign res.drive = drive_r;

endmodule

// ===== src/dws_merge.sv =====
// Merge stage: joins both lane results into one output transaction register.
// Depends on dws_pkg; instantiated by the top level.
module dws_merge
  import dws_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req,
  input  logic              idle_frame,
  input  lane_res_t         res_l,
  input  lane_res_t         res_r,
  output logic              load,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_drive_valid,
  output logic [DriveW-1:0] out_left_drive,
  output logic [DriveW-1:0] out_right_drive
);

  logic              valid_r;
  logic              dvalid_r;
  logic [DriveW-1:0] left_r;
  logic [DriveW-1:0] right_r;

  assign load = req && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
    if (load) begin
      dvalid_r <= !idle_frame;
      left_r   <= idle_frame ? '0 : res_l.drive;
      right_r  <= idle_frame ? '0 : res_r.drive;
    end
  end

  assign out_valid       = valid_r;
  assign out_drive_valid = dvalid_r;
  assign out_left_drive  = left_r;
  assign out_right_drive = right_r;

endmodule

// ===== src/dual_wheel_speed_pid.sv =====
// Dual-wheel speed PID controller with derivative on measurement.
// Input channel (in_*): one control frame per transaction, moving flag, optional
//   new targets and both encoder counts. in_stall is high while a frame is in work.
// Output channel (out_*): exactly one transaction per frame; out_drive_valid is 0
//   for an idle frame, with both drives 0.
// Configuration: cfg_we writes cfg_wdata to register cfg_idx (0 prop gain,
//   1 deriv gain, 2 integ gain, 3 divisor, 4 drive limit); write only while idle.
// Sequence: a moving frame steps each wheel lane through MP, MD, MI, SUM, DIV and
//   FIN, the 52-step serial divider working in DIV; the next frame may be taken in
//   the cycle after the output register is loaded. Idle frames skip the lanes.
// The two wheel lanes run in lockstep, each with one gain multiplier used three
//   times and its own divider; a merge stage fills the output register.
// Reset (rst_n low, synchronous) zeroes lane targets, counts, rates and integrals,
//   restores the register defaults. When the receiver stalls, the result holds in
//   the output register; one more frame may be accepted and worked on meanwhile.
module dual_wheel_speed_pid
  import dws_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [GainW-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_moving,
  input  logic                in_load_targets,
  input  logic [TargetW-1:0]  in_left_target,
  input  logic [TargetW-1:0]  in_right_target,
  input  logic [CountW-1:0]   in_left_count,
  input  logic [CountW-1:0]   in_right_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_drive_valid,
  output logic [DriveW-1:0]   out_left_drive,
  output logic [DriveW-1:0]   out_right_drive
);

  logic [GainW-1:0]  prop_r, deriv_r, integ_r, div_r;
  logic [LimitW-1:0] limit_r;
  logic              fly_r;
  logic              idle_r;
  logic              accept;
  logic              req;
  logic              load;
  cfg_t              cfg;
  lane_cmd_t         cmd_l, cmd_r;
  lane_res_t         res_l, res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_r  <= PropReset;
      deriv_r <= DerivReset;
      integ_r <= IntegReset;
      div_r   <= DivisorReset;
      limit_r <= LimitReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PROP:    prop_r  <= cfg_wdata;
        REG_DERIV:   deriv_r <= cfg_wdata;
        REG_INTEG:   integ_r <= cfg_wdata;
        REG_DIVISOR: div_r   <= cfg_wdata;
        REG_LIMIT:   limit_r <= cfg_wdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.prop_gain  = prop_r;
  assign cfg.deriv_gain = deriv_r;
  assign cfg.integ_gain = integ_r;
  assign cfg.divisor    = (div_r == '0) ? GainW'(1) : div_r;
  assign cfg.max_drive  = limit_r;

  assign in_stall = fly_r;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fly_r <= 1'b0;
    end else if (accept) begin
      fly_r <= 1'b1;
    end else if (load) begin
      fly_r <= 1'b0;
    end
    if (accept) begin
      idle_r <= !in_moving;
    end
  end

  assign cmd_l.start  = accept;
  assign cmd_l.moving = in_moving;
  assign cmd_l.load   = in_load_targets;
  assign cmd_l.target = in_left_target;
  assign cmd_l.count  = in_left_count;

  assign cmd_r.start  = accept;
  assign cmd_r.moving = in_moving;
  assign cmd_r.load   = in_load_targets;
  assign cmd_r.target = in_right_target;
  assign cmd_r.count  = in_right_count;

  dws_lane u_lane_l (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .cmd   (cmd_l),
    .ack   (load),
    .res   (res_l)
  );

  dws_lane u_lane_r (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .cmd   (cmd_r),
    .ack   (load),
    .res   (res_r)
  );

  assign req = fly_r && (idle_r || (res_l.done && res_r.done));

  dws_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .idle_frame      (idle_r),
    .res_l           (res_l),
    .res_r           (res_r),
    .load            (load),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_valid (out_drive_valid),
    .out_left_drive  (out_left_drive),
    .out_right_drive (out_right_drive)
  );

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    res_l.done == res_r.done)
    else $error("wheel lanes out of step");

  a_done_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_l.done |-> fly_r)
    else $error("lane result without a frame in work");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_drive_valid |-> out_left_drive == '0 && out_right_drive == '0)
    else $error("idle frame with nonzero drive");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("second frame accepted while one is in work");

endmodule
